// ===== sv/efcd_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the escaped frame decoder.
package efcd_pkg;

  // Line symbols
  localparam logic [7:0] SYM_START   = 8'h7E;
  localparam logic [7:0] SYM_ESC     = 8'h7D;
  localparam logic [7:0] SYM_FLIP    = 8'h20;
  localparam logic [7:0] SYM_NEWLINE = 8'h0A;

  // CRC-16/XMODEM
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Default payload buffer depth
  localparam int PAYLOAD_MAX_DEF = 32;

  // Receive phases
  typedef enum logic [2:0] {
    PH_WAIT_NL = 3'd0,
    PH_HUNT    = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_DATA    = 3'd4,
    PH_CRC     = 3'd5
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_PROTO = 2'd1,
    ST_CRC   = 2'd2
  } status_t;

  // Emitter states
  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_LOAD = 2'd1,
    EM_HOLD = 2'd2
  } emit_state_t;

  // Job handed from the parser to the emitter when a byte ends a frame
  typedef struct packed {
    status_t    status;
    logic [7:0] ftype;
    logic [7:0] flen;
  } efcd_job_t;

  // One byte of CRC-16, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/efcd_in_if.sv =====
// Input channel: one raw line byte per beat.
interface efcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/efcd_out_if.sv =====
// Result channel: one decoded result per beat.
interface efcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic       has_data;
  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic       last;

  modport source (output valid, output status, output frame_type, output frame_length,
                  output has_data, output payload_byte, output byte_index, output last,
                  input ready);
  modport sink   (input valid, input status, input frame_type, input frame_length,
                  input has_data, input payload_byte, input byte_index, input last,
                  output ready);
endinterface

// ===== sv/escaped_frame_crc16_decoder.sv =====
// A byte that ends a frame or hits a start inside one shows its result the next cycle;
// a good frame's first payload result passes through the RAM read register and EM_LOAD first.
// Throughput: one byte per cycle while no result is pending; a good frame with N stored bytes
// holds the input while they are read back through the payload RAM read port and emitted, output stalls included.
// Reset: synchronous, active low; clears phase, escape, CRC, header and sequencer state.
// The payload RAM is not cleared; a good frame only reads entries written during that frame.
module escaped_frame_crc16_decoder import efcd_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input logic         clk,
  input logic         rst_n,
  efcd_in_if.sink     in_ch,
  efcd_out_if.source  out_ch
);

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  logic          accept;
  logic          idle;
  logic          job_valid;
  efcd_job_t     job;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Input taken only while no result is pending, so RAM writes and reads never overlap
  assign in_ch.ready = idle;
  assign accept      = in_ch.valid && idle;

  efcd_parser #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_ch.rx_byte),
    .job_valid (job_valid),
    .job       (job),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  efcd_payload_ram #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  efcd_emitter #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_emitter (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (job_valid),
    .job              (job),
    .idle             (idle),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_frame_type   (out_ch.frame_type),
    .out_frame_length (out_ch.frame_length),
    .out_has_data     (out_ch.has_data),
    .out_payload_byte (out_ch.payload_byte),
    .out_byte_index   (out_ch.byte_index),
    .out_last         (out_ch.last)
  );

endmodule

// ===== sv/efcd_payload_ram.sv =====
// Payload buffer: one write port, one registered read port.
module efcd_payload_ram import efcd_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [PAYLOAD_MAX];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/efcd_parser.sv =====
// Receive parser: newline sync, unescaping, header capture, CRC check, payload writes.
module efcd_parser import efcd_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          job_valid,
  output efcd_job_t     job,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  ub;
  logic [7:0]  pos_inc;

  // Byte after escape removal
  assign ub      = esc_r ? (rx_byte ^ SYM_FLIP) : rx_byte;
  assign pos_inc = pos_r + 8'd1;

  // Next state and per-byte outputs
  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    job_valid  = 1'b0;
    job        = '{status: ST_GOOD, ftype: 8'h00, flen: 8'h00};
    wr_en      = 1'b0;
    wr_addr    = pos_r[AW-1:0];
    wr_data    = ub;

    if (accept) begin
      if (phase_r == PH_WAIT_NL) begin
        if (rx_byte == SYM_NEWLINE) begin
          phase_nxt = PH_HUNT;
        end
      end else if (rx_byte == SYM_START) begin
        // raw start always opens a frame; inside a frame it is an error
        phase_nxt = PH_TYPE;
        esc_nxt   = 1'b0;
        if (phase_r != PH_HUNT) begin
          job_valid  = 1'b1;
          job.status = ST_PROTO;
        end
      end else if (phase_r == PH_HUNT) begin
        // no frame open, drop the byte
      end else if (!esc_r && rx_byte == SYM_ESC) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        case (phase_r)
          PH_TYPE: begin
            type_nxt  = ub;
            crc_nxt   = crc16_step(16'h0000, ub);
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            len_nxt    = ub;
            crc_nxt    = crc16_step(crc_r, ub);
            phase_nxt  = (ub != 8'd0) ? PH_DATA : PH_CRC;
            pos_nxt    = 8'd0;
            crc_lo_nxt = 8'h00;
          end
          PH_DATA: begin
            // bytes past the buffer still count and enter the CRC
            wr_en   = (pos_r < 8'(PAYLOAD_MAX));
            crc_nxt = crc16_step(crc_r, ub);
            pos_nxt = pos_inc;
            if (pos_inc >= len_r) begin
              phase_nxt = PH_CRC;
              pos_nxt   = 8'd0;
            end
          end
          PH_CRC: begin
            if (!pos_r[0]) begin
              crc_lo_nxt = ub;
              pos_nxt    = 8'd1;
            end else begin
              pos_nxt   = 8'd2;
              phase_nxt = PH_HUNT;
              job_valid = 1'b1;
              job.ftype = type_r;
              job.flen  = len_r;
              job.status = ({ub, crc_lo_r} != crc_r) ? ST_CRC : ST_GOOD;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT_NL;
      esc_r    <= 1'b0;
      pos_r    <= 8'd0;
      crc_r    <= 16'h0000;
      crc_lo_r <= 8'h00;
      type_r   <= 8'h00;
      len_r    <= 8'h00;
    end else begin
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

// ===== sv/efcd_emitter.sv =====
// Result sequencer: reads stored payload back and drives the output register.
module efcd_emitter import efcd_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1,
  localparam int CW = $clog2(PAYLOAD_MAX + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  efcd_job_t     job,
  output logic          idle,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [7:0]    out_frame_type,
  output logic [7:0]    out_frame_length,
  output logic          out_has_data,
  output logic [7:0]    out_payload_byte,
  output logic [5:0]    out_byte_index,
  output logic          out_last
);

  emit_state_t state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] job_cnt;
  logic          job_multi;
  logic [1:0]    status_r;
  logic [7:0]    type_r;
  logic [7:0]    len_r;
  logic          has_data_r;
  logic [7:0]    payload_r;
  logic [5:0]    index_r;
  logic          last_r;

  // Good frames with payload stream stored bytes; everything else is one result
  assign job_multi = (job.status == ST_GOOD) && (job.flen != 8'd0);
  assign job_cnt   = (job.flen > 8'(PAYLOAD_MAX)) ? CW'(PAYLOAD_MAX) : CW'(job.flen);

  // Sequencer: issue read, load result, hold until taken
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r[AW-1:0];
    case (state_r)
      EM_IDLE: begin
        if (job_valid) begin
          if (job_multi) begin
            idx_nxt   = '0;
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = EM_LOAD;
          end else begin
            state_nxt = EM_HOLD;
          end
        end
      end
      EM_LOAD: begin
        state_nxt = EM_HOLD;
      end
      EM_HOLD: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = EM_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            rd_en     = 1'b1;
            rd_addr   = idx_nxt[AW-1:0];
            state_nxt = EM_LOAD;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state_r == EM_IDLE && job_valid) begin
      status_r   <= job.status;
      type_r     <= job.ftype;
      len_r      <= job.flen;
      cnt_r      <= job_cnt;
      has_data_r <= 1'b0;
      payload_r  <= 8'h00;
      index_r    <= 6'd0;
      last_r     <= 1'b1;
    end else if (state_r == EM_LOAD) begin
      has_data_r <= 1'b1;
      payload_r  <= rd_data;
      index_r    <= 6'(idx_r);
      last_r     <= ((idx_r + CW'(1)) == cnt_r);
    end
  end

  assign idle             = (state_r == EM_IDLE);
  assign out_valid        = (state_r == EM_HOLD);
  assign out_status       = status_r;
  assign out_frame_type   = type_r;
  assign out_frame_length = len_r;
  assign out_has_data     = has_data_r;
  assign out_payload_byte = payload_r;
  assign out_byte_index   = index_r;
  assign out_last         = last_r;

endmodule

// ===== dv/tb_escaped_frame_crc16_decoder.sv =====
// Self-checking testbench for the escaped frame decoder: byte stream in, decoded frame results out.
`timescale 1ns / 100ps

module tb_escaped_frame_crc16_decoder;
  import efcd_pkg::*;

  localparam int PAYLOAD_MAX  = PAYLOAD_MAX_DEF;
  localparam int PHASE_BYTES  = 25;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 500000;

  // One decoded result as seen on the output channel
  typedef struct packed {
    status_t    status;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       has_data;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;
  } frame_result_t;

  logic clk;
  logic rst_n;

  efcd_in_if  in_ch();
  efcd_out_if out_ch();

  escaped_frame_crc16_decoder #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Line bytes waiting to be driven, and results the decoder still owes
  logic [7:0]    line_bytes[$];
  frame_result_t frame_results_due[$];
  frame_result_t due_head;
  logic [7:0]    frame_body[256];
  int            queued_count;
  int            fail_count;
  int            cycle_count;
  int            tx_idle_pct;
  int            rx_stall_pct;

  // Decoder shadow state
  phase_t        dec_phase;
  logic          dec_escape;
  logic [7:0]    dec_pos;
  logic [15:0]   dec_crc;
  logic [15:0]   dec_crc_seen;
  logic [7:0]    dec_type;
  logic [7:0]    dec_len;
  logic [7:0]    payload_copy[PAYLOAD_MAX];

  // CRC-16/XMODEM, one byte, feedback form
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void post_result(input status_t st, input logic [7:0] ty,
                                      input logic [7:0] len, input logic hd,
                                      input logic [7:0] pb, input logic [5:0] idx,
                                      input logic lst);
    frame_result_t r;
    r.status       = st;
    r.frame_type   = ty;
    r.frame_length = len;
    r.has_data     = hd;
    r.payload_byte = pb;
    r.byte_index   = idx;
    r.last         = lst;
    frame_results_due.push_back(r);
  endfunction

  // Advance the shadow decoder by one accepted line byte
  function automatic void decode_line_byte(input logic [7:0] raw);
    logic [7:0] b;
    int         n;
    b = raw;
    if (dec_phase == PH_WAIT_NL) begin
      if (b == SYM_NEWLINE) begin
        dec_phase = PH_HUNT;
      end
      return;
    end
    // raw start byte always opens a new frame; inside a frame it flags an error
    if (b == SYM_START) begin
      if (dec_phase != PH_HUNT) begin
        post_result(ST_PROTO, 8'h00, 8'h00, 1'b0, 8'h00, 6'd0, 1'b1);
      end
      dec_phase  = PH_TYPE;
      dec_escape = 1'b0;
      return;
    end
    if (dec_phase == PH_HUNT) begin
      return;
    end
    if (dec_escape) begin
      b = b ^ SYM_FLIP;
      dec_escape = 1'b0;
    end else if (b == SYM_ESC) begin
      dec_escape = 1'b1;
      return;
    end
    case (dec_phase)
      PH_TYPE: begin
        dec_type  = b;
        dec_crc   = crc16_update(16'h0000, b);
        dec_phase = PH_LEN;
      end
      PH_LEN: begin
        dec_len      = b;
        dec_crc      = crc16_update(dec_crc, b);
        dec_phase    = (b != 8'h00) ? PH_DATA : PH_CRC;
        dec_pos      = 8'h00;
        dec_crc_seen = 16'h0000;
      end
      PH_DATA: begin
        // bytes past the buffer still count and enter the CRC
        if (dec_pos < PAYLOAD_MAX) begin
          payload_copy[dec_pos] = b;
        end
        dec_crc = crc16_update(dec_crc, b);
        dec_pos = dec_pos + 8'd1;
        if (dec_pos >= dec_len) begin
          dec_phase = PH_CRC;
          dec_pos   = 8'h00;
        end
      end
      PH_CRC: begin
        // little-endian CRC, low byte first
        dec_crc_seen = dec_crc_seen | (16'(b) << (dec_pos[0] ? 8 : 0));
        dec_pos = dec_pos + 8'd1;
        if (dec_pos >= 8'd2) begin
          dec_phase = PH_HUNT;
          if (dec_crc_seen != dec_crc) begin
            post_result(ST_CRC, dec_type, dec_len, 1'b0, 8'h00, 6'd0, 1'b1);
          end else if (dec_len == 8'h00) begin
            post_result(ST_GOOD, dec_type, dec_len, 1'b0, 8'h00, 6'd0, 1'b1);
          end else begin
            n = (dec_len > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(dec_len);
            for (int i = 0; i < n; i++) begin
              post_result(ST_GOOD, dec_type, dec_len, 1'b1, payload_copy[i], 6'(i),
                          i == n - 1);
            end
          end
        end
      end
      default: dec_phase = PH_HUNT;
    endcase
  endfunction

  function automatic void put_line_byte(input logic [7:0] x);
    line_bytes.push_back(x);
    queued_count++;
  endfunction

  // Byte stuffing: start and escape always escaped, others now and then, but never start ^ flip
  function automatic void put_stuffed(input logic [7:0] x);
    if (x == SYM_START || x == SYM_ESC ||
        (x != (SYM_START ^ SYM_FLIP) && $urandom_range(0, 9) == 0)) begin
      put_line_byte(SYM_ESC);
      put_line_byte(x ^ SYM_FLIP);
    end else begin
      put_line_byte(x);
    end
  endfunction

  // Random byte biased toward the framing symbols
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return SYM_START;
      1:       return SYM_ESC;
      2:       return SYM_START ^ SYM_FLIP;
      3:       return SYM_NEWLINE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Start byte, then type, length, frame_body and CRC; keep < 0 sends it whole,
  // otherwise only the first keep unescaped bytes go out
  function automatic void queue_frame(input logic [7:0] ftype, input int flen,
                                      input logic [15:0] crc_err, input int keep);
    logic [15:0] crc;
    logic [7:0]  fbyte;
    int          n_keep;
    crc = crc16_update(16'h0000, ftype);
    crc = crc16_update(crc, 8'(flen));
    for (int i = 0; i < flen; i++) begin
      crc = crc16_update(crc, frame_body[i]);
    end
    crc = crc ^ crc_err;
    n_keep = (keep < 0 || keep > flen + 4) ? flen + 4 : keep;
    put_line_byte(SYM_START);
    for (int k = 0; k < n_keep; k++) begin
      if (k == 0) begin
        fbyte = ftype;
      end else if (k == 1) begin
        fbyte = 8'(flen);
      end else if (k < flen + 2) begin
        fbyte = frame_body[k - 2];
      end else if (k == flen + 2) begin
        fbyte = crc[7:0];
      end else begin
        fbyte = crc[15:8];
      end
      put_stuffed(fbyte);
    end
  endfunction

  // Mostly well-formed frames, some bad CRCs, cut frames and line noise
  function automatic void queue_traffic(input int n_bytes);
    int stop_at;
    int kind;
    int pick;
    int flen;
    stop_at = queued_count + n_bytes;
    while (queued_count < stop_at) begin
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      flen = (pick < 55) ? $urandom_range(0, 4) :
             (pick < 90) ? $urandom_range(5, 34) : $urandom_range(35, 70);
      for (int i = 0; i < flen; i++) begin
        frame_body[i] = pick_byte();
      end
      if (kind < 70) begin
        queue_frame(pick_byte(), flen, 16'h0000, -1);
      end else if (kind < 80) begin
        queue_frame(pick_byte(), flen, 16'($urandom_range(1, 65535)), -1);
      end else if (kind < 90) begin
        queue_frame(pick_byte(), flen, 16'h0000, $urandom_range(0, flen + 3));
      end else begin
        repeat ($urandom_range(1, 4)) put_line_byte(pick_byte());
      end
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Driver: feeds line bytes, tracks accepted beats into the shadow decoder
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'h00;
      dec_phase     = PH_WAIT_NL;
      dec_escape    = 1'b0;
      dec_pos       = 8'h00;
      dec_crc       = 16'h0000;
      dec_crc_seen  = 16'h0000;
      dec_type      = 8'h00;
      dec_len       = 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_line_byte(in_ch.rx_byte);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (line_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.rx_byte <= line_bytes.pop_front();
        end else begin
          in_ch.valid   <= 1'b0;
          in_ch.rx_byte <= 8'($urandom_range(0, 255));
        end
      end
    end
  end

  // Monitor: random backpressure, compares each result beat with the oldest one due
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t: stray result beat, expected none, actual st %0d type %0d len %0d",
                   $time, out_ch.status, out_ch.frame_type, out_ch.frame_length);
          fail_count++;
        end else begin
          due_head = frame_results_due.pop_front();
          check_field("status", due_head.status, out_ch.status);
          check_field("frame_type", due_head.frame_type, out_ch.frame_type);
          check_field("frame_length", due_head.frame_length, out_ch.frame_length);
          check_field("has_data", due_head.has_data, out_ch.has_data);
          check_field("payload_byte", due_head.payload_byte, out_ch.payload_byte);
          check_field("byte_index", due_head.byte_index, out_ch.byte_index);
          check_field("last", due_head.last, out_ch.last);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Stimulus sequence
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    queued_count  = 0;
    fail_count    = 0;
    cycle_count   = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ignored until the first newline, a start byte included
    put_line_byte(SYM_START);
    put_line_byte(8'hFF);
    put_line_byte(8'h00);
    put_line_byte(SYM_ESC);
    put_line_byte(SYM_NEWLINE);
    // noise while hunting
    put_line_byte(8'h41);
    // empty good frame
    queue_frame(8'hFF, 0, 16'h0000, -1);
    // escaped type and payload
    frame_body[0] = SYM_START;
    queue_frame(SYM_ESC, 1, 16'h0000, -1);
    // CRC mismatch
    frame_body[0] = 8'h00;
    frame_body[1] = 8'hFF;
    queue_frame(8'h00, 2, 16'h0001, -1);
    // start during length, payload and CRC
    queue_frame(8'h5A, 3, 16'h0000, 1);
    queue_frame(8'h5A, 3, 16'h0000, 3);
    queue_frame(8'hA5, 0, 16'h0000, 3);
    // escape followed by a raw start byte restarts the frame
    put_line_byte(SYM_START);
    put_line_byte(SYM_ESC);
    frame_body[0] = SYM_NEWLINE;
    queue_frame(8'h80, 1, 16'h0000, -1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase
      if (ph == 0) begin
        // longest frame: payload overruns the buffer
        for (int i = 0; i < 255; i++) begin
          frame_body[i] = pick_byte();
        end
        queue_frame(pick_byte(), 255, 16'h0000, -1);
      end
      queue_traffic(PHASE_BYTES);
      // sender holds off until the decoder has delivered everything owed
      while (line_bytes.size() != 0 || in_ch.valid || frame_results_due.size() != 0) begin
        @(negedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/efcd_pkg.sv
sv/efcd_in_if.sv
sv/efcd_out_if.sv
sv/efcd_payload_ram.sv
sv/efcd_parser.sv
sv/efcd_emitter.sv
sv/escaped_frame_crc16_decoder.sv
dv/tb_escaped_frame_crc16_decoder.sv
